// ===== rtl/esb_pkg.sv =====
// Package for the enveloped sine beeper: widths, register indexes, reset values,
// the arithmetic unit's control struct and the sine table entry function.
// Has no dependencies. Every other file of the block uses it.
package esb_pkg;

   localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;
   localparam int LENGTH_WIDTH_DEFAULT     = 24;

   localparam int PHASE_W     = 32;
   localparam int CFG_LEN_W   = 24;
   localparam int LEVEL_W     = 16;
   localparam int SAMPLE_W    = 16;
   localparam int NOTE_W      = 24;
   localparam int CMP_W       = 32;
   localparam int MUL_A_W     = 33;
   localparam int MUL_B_W     = 18;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int QUO_W       = 16;
   localparam int REM_W       = CFG_LEN_W;
   localparam int SAMPLE_SHIFT = 15;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_PHASE_STEP   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_LENGTH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSITION_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_LENGTH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_LEVEL        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSTAIN_LEVEL     = 3'd5;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   localparam logic [PHASE_W-1:0]   RESET_TONE_PHASE_STEP   = 32'd0;
   localparam logic [CFG_LEN_W-1:0] RESET_ATTACK_LENGTH     = 24'd1470;
   localparam logic [CFG_LEN_W-1:0] RESET_TRANSITION_LENGTH = 24'd1470;
   localparam logic [CFG_LEN_W-1:0] RESET_RELEASE_LENGTH    = 24'd4410;
   localparam logic [LEVEL_W-1:0]   RESET_PEAK_LEVEL        = 16'd50000;
   localparam logic [LEVEL_W-1:0]   RESET_SUSTAIN_LEVEL     = 16'd35000;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic mul_go;
      logic div_load;
      logic div_step;
   } arith_ctl_type;

   // Q1.15 sine of a 16-bit turn fraction: quarter-wave fold, Taylor series in Q30
   function automatic logic signed [SAMPLE_W-1:0] sine_value(input logic [15:0] turn);
      logic [1:0]  quad;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      quad = turn[15:14];
      r = {50'd0, turn[13:0]};
      if (quad[0]) begin
         r = 64'd16384 - r;
      end
      x  = (r * HALF_PI_Q30) >> 14;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - ((x2 * Q30_ONE / 64'd110) >> 30);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return quad[1] ? -$signed(v[SAMPLE_W-1:0]) : $signed(v[SAMPLE_W-1:0]);
   endfunction

endpackage

// ===== rtl/esb_sine_rom.sv =====
// Sine lookup table with registered read, filled with constants at elaboration.
// Depends on esb_pkg for the entry function and sample width.
module esb_sine_rom #(
   parameter int SINE_TABLE_DEPTH = esb_pkg::SINE_TABLE_DEPTH_DEFAULT,
   localparam int INDEX_WIDTH = $clog2(SINE_TABLE_DEPTH)
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [INDEX_WIDTH-1:0]               rd_index,
   output logic signed [esb_pkg::SAMPLE_W-1:0]  rd_data
);

   logic signed [esb_pkg::SAMPLE_W-1:0] table_w [SINE_TABLE_DEPTH];
   logic signed [esb_pkg::SAMPLE_W-1:0] data_ff;

   for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_entry
      localparam logic [15:0] TURN = 16'((64'(gi) << 16) / SINE_TABLE_DEPTH);
      assign table_w[gi] = esb_pkg::sine_value(TURN);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= table_w[rd_index];
      end
   end

   assign rd_data = data_ff;

endmodule

// ===== rtl/esb_mul_div.sv =====
// Shared arithmetic unit: one registered signed multiplier and a restoring
// divider that retires one quotient bit per cycle while div_step is high. Depends on esb_pkg.
module esb_mul_div (
   input  logic                                  clock,
   input  esb_pkg::arith_ctl_type                ctl,
   input  logic signed [esb_pkg::MUL_A_W-1:0]    mul_a,
   input  logic signed [esb_pkg::MUL_B_W-1:0]    mul_b,
   input  logic [esb_pkg::CFG_LEN_W-1:0]         divisor,
   output logic signed [esb_pkg::MUL_P_W-1:0]    product,
   output logic [esb_pkg::QUO_W-1:0]             quotient
);

   logic signed [esb_pkg::MUL_P_W-1:0] product_ff;
   logic signed [esb_pkg::MUL_P_W-1:0] product_in;
   logic [esb_pkg::REM_W-1:0]          rem_ff;
   logic [esb_pkg::REM_W-1:0]          rem_in;
   logic [esb_pkg::QUO_W-1:0]          quo_ff;
   logic [esb_pkg::QUO_W-1:0]          quo_in;
   logic [esb_pkg::REM_W:0]            shifted;
   logic [esb_pkg::REM_W+1:0]          trial;
   logic                               fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[esb_pkg::QUO_W-1]};
      trial   = {1'b0, shifted} - {2'b00, divisor};
      fits    = !trial[esb_pkg::REM_W+1];

      product_in = product_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (ctl.mul_go) begin
         product_in = mul_a * mul_b;
      end
      if (ctl.div_load) begin
         rem_in = product_ff[esb_pkg::QUO_W +: esb_pkg::REM_W];
         quo_in = product_ff[esb_pkg::QUO_W-1:0];
      end else if (ctl.div_step) begin
         rem_in = fits ? trial[esb_pkg::REM_W-1:0] : shifted[esb_pkg::REM_W-1:0];
         quo_in = {quo_ff[esb_pkg::QUO_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
   end

   assign product = product_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/enveloped_sine_beeper.sv =====
// Top level of the enveloped sine beeper: sequencer, note state, registers
// and output register. Depends on esb_pkg, esb_sine_rom and esb_mul_div.
//
// Usage:
//   req_*  : one transaction per item. req_type high loads req_note_length as
//            the remaining note length and gives no result; req_type low is a
//            sample tick and gives exactly one rsp_* transaction.
//   rsp_*  : rsp_sample is the enveloped sine sample, rsp_active is high while
//            a note sounds. Held in an output register until taken.
//   csr_*  : register writes, always ready; write only while the block is idle.
// Sequence: req_stall is high while a tick is in work. A load is handled in idle;
//   a silent tick goes to ST_DONE, a tick in sustain through ST_SETUP, ST_SCALE and
//   ST_DONE, a ramp tick also through ST_LOAD and the 16-step serial ramp divider.
// Reset clears note state and phase and loads the register defaults.
// When the receiver stalls, the finished sample waits in the final state and
//   the next item is only taken once that sample has moved to the output register.
module enveloped_sine_beeper #(
   parameter int SINE_TABLE_DEPTH = esb_pkg::SINE_TABLE_DEPTH_DEFAULT,
   parameter int LENGTH_WIDTH     = esb_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_type,
   input  logic [esb_pkg::NOTE_W-1:0]             req_note_length,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [esb_pkg::SAMPLE_W-1:0]    rsp_sample,
   output logic                                   rsp_active,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [esb_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [esb_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int SINE_INDEX_WIDTH = $clog2(SINE_TABLE_DEPTH);
   localparam int COUNT_W = $clog2(esb_pkg::QUO_W);
   localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(esb_pkg::QUO_W - 1);
   localparam logic signed [esb_pkg::MUL_B_W-1:0] DEPTH_OPERAND =
      esb_pkg::MUL_B_W'(SINE_TABLE_DEPTH);
   localparam logic signed [esb_pkg::MUL_P_W-1:0] SAT_HI = esb_pkg::MUL_P_W'(32767);
   localparam logic signed [esb_pkg::MUL_P_W-1:0] SAT_LO = -(esb_pkg::MUL_P_W'(32768));

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SETUP  = 7'b0000010,
      ST_LOAD   = 7'b0000100,
      ST_DIVIDE = 7'b0001000,
      ST_SCALE  = 7'b0010000,
      ST_DONE   = 7'b0100000,
      ST_SPARE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [esb_pkg::PHASE_W-1:0]   step_ff, step_in;
   logic [esb_pkg::CFG_LEN_W-1:0] attack_ff, attack_in;
   logic [esb_pkg::CFG_LEN_W-1:0] trans_ff, trans_in;
   logic [esb_pkg::CFG_LEN_W-1:0] release_ff, release_in;
   logic [esb_pkg::LEVEL_W-1:0]   peak_ff, peak_in;
   logic [esb_pkg::LEVEL_W-1:0]   sustain_ff, sustain_in;

   logic [LENGTH_WIDTH-1:0]       remaining_ff, remaining_in;
   logic [LENGTH_WIDTH-1:0]       elapsed_ff, elapsed_in;
   logic [esb_pkg::PHASE_W-1:0]   phase_ff, phase_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [esb_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_active_ff, rsp_active_in;

   logic                          silent_ff, silent_in;
   logic                          ramp_ff, ramp_in;
   logic                          sub_ff, sub_in;
   logic [esb_pkg::LEVEL_W-1:0]   base_ff, base_in;
   logic [esb_pkg::CFG_LEN_W-1:0] divisor_ff, divisor_in;
   logic [COUNT_W-1:0]            count_ff, count_in;

   logic                          req_accept;
   logic                          out_free;
   logic [esb_pkg::CMP_W-1:0]     rem_w, ela_w, d_w;
   logic                          in_release, in_attack, in_trans, peak_ge;
   logic [esb_pkg::LEVEL_W-1:0]   gap;
   logic [esb_pkg::CMP_W-1:0]     ramp_num;
   logic [esb_pkg::LEVEL_W-1:0]   ramp_gain;
   logic [esb_pkg::LEVEL_W-1:0]   level_w;
   logic signed [esb_pkg::MUL_P_W-1:0] scaled;
   logic signed [esb_pkg::SAMPLE_W-1:0] sample_sat;

   esb_pkg::arith_ctl_type               arith_ctl;
   logic signed [esb_pkg::MUL_A_W-1:0]   mul_a;
   logic signed [esb_pkg::MUL_B_W-1:0]   mul_b;
   logic signed [esb_pkg::MUL_P_W-1:0]   product;
   logic [esb_pkg::QUO_W-1:0]            quotient;
   logic                                 rom_rd_en;
   logic signed [esb_pkg::SAMPLE_W-1:0]  rom_data;

   esb_mul_div u_mul_div (
      .clock    (clock),
      .ctl      (arith_ctl),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .divisor  (divisor_ff),
      .product  (product),
      .quotient (quotient)
   );

   esb_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .clock    (clock),
      .rd_en    (rom_rd_en),
      .rd_index (product[esb_pkg::PHASE_W +: SINE_INDEX_WIDTH]),
      .rd_data  (rom_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      rem_w      = esb_pkg::CMP_W'(remaining_ff);
      ela_w      = esb_pkg::CMP_W'(elapsed_ff);
      d_w        = ela_w - esb_pkg::CMP_W'(attack_ff);
      in_release = rem_w <= esb_pkg::CMP_W'(release_ff);
      in_attack  = ela_w < esb_pkg::CMP_W'(attack_ff);
      in_trans   = d_w < esb_pkg::CMP_W'(trans_ff);
      peak_ge    = peak_ff >= sustain_ff;
      gap        = peak_ge ? (peak_ff - sustain_ff) : (sustain_ff - peak_ff);

      ramp_in    = 1'b1;
      sub_in     = 1'b0;
      base_in    = '0;
      divisor_in = release_ff;
      ramp_num   = rem_w;
      ramp_gain  = sustain_ff;
      if (in_release) begin
         ramp_in = 1'b1;
      end else if (in_attack) begin
         divisor_in = attack_ff;
         ramp_num   = ela_w;
         ramp_gain  = peak_ff;
      end else if (in_trans) begin
         divisor_in = trans_ff;
         ramp_num   = d_w;
         ramp_gain  = gap;
         base_in    = peak_ff;
         sub_in     = peak_ge;
      end else begin
         ramp_in = 1'b0;
         base_in = sustain_ff;
      end

      if (!ramp_ff) begin
         level_w = base_ff;
      end else if (sub_ff) begin
         level_w = base_ff - quotient;
      end else begin
         level_w = base_ff + quotient;
      end

      scaled = product >>> esb_pkg::SAMPLE_SHIFT;
      if (scaled > SAT_HI) begin
         sample_sat = 16'sh7fff;
      end else if (scaled < SAT_LO) begin
         sample_sat = -16'sh8000;
      end else begin
         sample_sat = scaled[esb_pkg::SAMPLE_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      attack_in     = attack_ff;
      trans_in      = trans_ff;
      release_in    = release_ff;
      peak_in       = peak_ff;
      sustain_in    = sustain_ff;
      remaining_in  = remaining_ff;
      elapsed_in    = elapsed_ff;
      phase_in      = phase_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_active_in = rsp_active_ff;
      silent_in     = silent_ff;
      count_in      = count_ff;
      arith_ctl     = '0;
      mul_a         = '0;
      mul_b         = '0;
      rom_rd_en     = 1'b0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            esb_pkg::CSR_TONE_PHASE_STEP:   step_in    = csr_data;
            esb_pkg::CSR_ATTACK_LENGTH:     attack_in  = csr_data[esb_pkg::CFG_LEN_W-1:0];
            esb_pkg::CSR_TRANSITION_LENGTH: trans_in   = csr_data[esb_pkg::CFG_LEN_W-1:0];
            esb_pkg::CSR_RELEASE_LENGTH:    release_in = csr_data[esb_pkg::CFG_LEN_W-1:0];
            esb_pkg::CSR_PEAK_LEVEL:        peak_in    = csr_data[esb_pkg::LEVEL_W-1:0];
            esb_pkg::CSR_SUSTAIN_LEVEL:     sustain_in = csr_data[esb_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            mul_a = $signed({1'b0, phase_ff});
            mul_b = DEPTH_OPERAND;
            if (req_accept) begin
               if (req_type == esb_pkg::REQ_LOAD) begin
                  remaining_in = LENGTH_WIDTH'(req_note_length);
               end else begin
                  arith_ctl.mul_go = 1'b1;
                  silent_in = (remaining_ff == '0);
                  state_in  = (remaining_ff == '0) ? ST_DONE : ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            rom_rd_en        = 1'b1;
            arith_ctl.mul_go = 1'b1;
            mul_a = $signed({1'b0, ramp_num});
            mul_b = $signed({2'b00, ramp_gain});
            state_in = ramp_in ? ST_LOAD : ST_SCALE;
         end
         ST_LOAD: begin
            arith_ctl.div_load = 1'b1;
            count_in = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            arith_ctl.div_step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == COUNT_LAST) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            arith_ctl.mul_go = 1'b1;
            mul_a = $signed({{(esb_pkg::MUL_A_W-esb_pkg::LEVEL_W){1'b0}}, level_w});
            mul_b = esb_pkg::MUL_B_W'(rom_data);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = silent_ff ? '0 : sample_sat;
               rsp_active_in = !silent_ff;
               phase_in      = phase_ff + step_ff;
               if (silent_ff) begin
                  elapsed_in = '0;
               end else begin
                  remaining_in = remaining_ff - 1'b1;
                  if (elapsed_ff != '1) begin
                     elapsed_in = elapsed_ff + 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= esb_pkg::RESET_TONE_PHASE_STEP;
         attack_ff    <= esb_pkg::RESET_ATTACK_LENGTH;
         trans_ff     <= esb_pkg::RESET_TRANSITION_LENGTH;
         release_ff   <= esb_pkg::RESET_RELEASE_LENGTH;
         peak_ff      <= esb_pkg::RESET_PEAK_LEVEL;
         sustain_ff   <= esb_pkg::RESET_SUSTAIN_LEVEL;
         remaining_ff <= '0;
         elapsed_ff   <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         attack_ff    <= attack_in;
         trans_ff     <= trans_in;
         release_ff   <= release_in;
         peak_ff      <= peak_in;
         sustain_ff   <= sustain_in;
         remaining_ff <= remaining_in;
         elapsed_ff   <= elapsed_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_active_ff <= rsp_active_in;
      silent_ff     <= silent_in;
      count_ff      <= count_in;
      if (state_ff == ST_SETUP) begin
         ramp_ff    <= ramp_in;
         sub_ff     <= sub_in;
         base_ff    <= base_in;
         divisor_ff <= divisor_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_active = rsp_active_ff;

endmodule

// ===== sim/enveloped_sine_beeper_tb.sv =====
// Testbench for enveloped_sine_beeper: a stimulus table, then randomized note sequences,
// checked field by field against an in-bench tone and envelope predictor.
// Depends on esb_pkg and the enveloped_sine_beeper RTL.
`timescale 1ns / 100ps

module enveloped_sine_beeper_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int RANDOM_PHASES = 6;
   localparam logic [esb_pkg::CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [esb_pkg::CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;

   typedef enum logic [1:0] {ROW_TICK, ROW_LOAD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                        kind;
      logic [esb_pkg::CSR_INDEX_W-1:0]     index;
      logic [esb_pkg::CSR_DATA_W-1:0]      value;
      logic                                typed;
      logic signed [esb_pkg::SAMPLE_W-1:0] exp_sample;
      logic                                exp_active;
   } stim_row_type;

   typedef struct packed {
      logic signed [esb_pkg::SAMPLE_W-1:0] sample;
      logic                                active;
   } beep_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = esb_pkg::REQ_TICK;
   logic [esb_pkg::NOTE_W-1:0] req_note_length = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [esb_pkg::SAMPLE_W-1:0] rsp_sample;
   logic rsp_active;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [esb_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [esb_pkg::CSR_DATA_W-1:0] csr_data = '0;

   logic quiet = 1'b0;
   int   cycle_count = 0;
   int   mismatch_count = 0;
   int   items_sent = 0;

   beep_out_type pending_samples[$];
   stim_row_type stim_rows[$];

   logic [esb_pkg::PHASE_W-1:0]   cfg_step;
   logic [esb_pkg::CFG_LEN_W-1:0] cfg_attack;
   logic [esb_pkg::CFG_LEN_W-1:0] cfg_trans;
   logic [esb_pkg::CFG_LEN_W-1:0] cfg_release;
   logic [esb_pkg::LEVEL_W-1:0]   cfg_peak;
   logic [esb_pkg::LEVEL_W-1:0]   cfg_sustain;
   logic [esb_pkg::NOTE_W-1:0]    note_left;
   logic [esb_pkg::NOTE_W-1:0]    note_age;
   logic [esb_pkg::PHASE_W-1:0]   tone_phase;

   enveloped_sine_beeper u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_note_length (req_note_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_active      (rsp_active),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic signed [esb_pkg::SAMPLE_W-1:0] tone_sine(
      input logic [esb_pkg::PHASE_W-1:0] ph);
      logic [15:0] turn;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      logic signed [esb_pkg::SAMPLE_W-1:0] mag;
      turn = {ph[31:22], 6'd0};
      r = {50'd0, turn[13:0]};
      if (turn[14]) begin
         r = 64'd16384 - r;
      end
      x  = (r * 64'd1686629713) >> 14;
      x2 = (x * x) >> 30;
      t  = (64'd1 << 30) - (((x2 << 30) / 64'd110) >> 30);
      t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd72);
      t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd42);
      t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd20);
      t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      mag = v[esb_pkg::SAMPLE_W-1:0];
      return turn[15] ? -mag : mag;
   endfunction

   function automatic logic [esb_pkg::LEVEL_W-1:0] envelope_now();
      logic [63:0] ramp;
      logic [esb_pkg::CFG_LEN_W-1:0] d;
      if (note_left <= cfg_release) begin
         ramp = 64'(note_left) * 64'(cfg_sustain) / 64'(cfg_release);
         return ramp[esb_pkg::LEVEL_W-1:0];
      end
      if (note_age < cfg_attack) begin
         ramp = 64'(note_age) * 64'(cfg_peak) / 64'(cfg_attack);
         return ramp[esb_pkg::LEVEL_W-1:0];
      end
      d = note_age - cfg_attack;
      if (d < cfg_trans) begin
         if (cfg_peak >= cfg_sustain) begin
            ramp = 64'(d) * 64'(cfg_peak - cfg_sustain) / 64'(cfg_trans);
            return cfg_peak - ramp[esb_pkg::LEVEL_W-1:0];
         end
         ramp = 64'(d) * 64'(cfg_sustain - cfg_peak) / 64'(cfg_trans);
         return cfg_peak + ramp[esb_pkg::LEVEL_W-1:0];
      end
      return cfg_sustain;
   endfunction

   function automatic beep_out_type predict_tick();
      beep_out_type out;
      logic signed [63:0] prod;
      logic signed [63:0] q;
      logic [esb_pkg::LEVEL_W-1:0] level;
      logic signed [esb_pkg::SAMPLE_W-1:0] sine;
      if (note_left == '0) begin
         note_age = '0;
         out.sample = '0;
         out.active = 1'b0;
      end else begin
         level = envelope_now();
         sine = tone_sine(tone_phase);
         prod = $signed({48'd0, level}) * 64'(sine);
         q = prod >>> esb_pkg::SAMPLE_SHIFT;
         if (q > 64'sd32767) begin
            q = 64'sd32767;
         end else if (q < -64'sd32768) begin
            q = -64'sd32768;
         end
         out.sample = q[esb_pkg::SAMPLE_W-1:0];
         out.active = 1'b1;
         note_left = note_left - 1'b1;
         if (note_age != {esb_pkg::NOTE_W{1'b1}}) begin
            note_age = note_age + 1'b1;
         end
      end
      tone_phase = tone_phase + cfg_step;
      return out;
   endfunction

   task automatic apply_csr(input logic [esb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [esb_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         esb_pkg::CSR_TONE_PHASE_STEP:   cfg_step = val;
         esb_pkg::CSR_ATTACK_LENGTH:     cfg_attack = val[esb_pkg::CFG_LEN_W-1:0];
         esb_pkg::CSR_TRANSITION_LENGTH: cfg_trans = val[esb_pkg::CFG_LEN_W-1:0];
         esb_pkg::CSR_RELEASE_LENGTH:    cfg_release = val[esb_pkg::CFG_LEN_W-1:0];
         esb_pkg::CSR_PEAK_LEVEL:        cfg_peak = val[esb_pkg::LEVEL_W-1:0];
         esb_pkg::CSR_SUSTAIN_LEVEL:     cfg_sustain = val[esb_pkg::LEVEL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_item(input logic kind, input logic [esb_pkg::NOTE_W-1:0] len,
                            input logic typed, input logic signed [esb_pkg::SAMPLE_W-1:0] s,
                            input logic a);
      beep_out_type exp_out;
      if (!quiet && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_note_length <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (kind == esb_pkg::REQ_LOAD) begin
         note_left = len;
      end else begin
         exp_out = predict_tick();
         if (typed) begin
            exp_out.sample = s;
            exp_out.active = a;
         end
         pending_samples.push_back(exp_out);
      end
   endtask

   task automatic send_load(input logic [esb_pkg::NOTE_W-1:0] len);
      send_item(esb_pkg::REQ_LOAD, len, 1'b0, '0, 1'b0);
   endtask

   task automatic send_tick();
      send_item(esb_pkg::REQ_TICK, '0, 1'b0, '0, 1'b0);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   task automatic settle_block();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [esb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [esb_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, val);
   endtask

   task automatic add_row(input row_kind_type kind, input logic [esb_pkg::CSR_INDEX_W-1:0] idx,
                          input logic [esb_pkg::CSR_DATA_W-1:0] val, input logic typed,
                          input logic signed [esb_pkg::SAMPLE_W-1:0] s, input logic a);
      stim_row_type row;
      row.kind = kind;
      row.index = idx;
      row.value = val;
      row.typed = typed;
      row.exp_sample = s;
      row.exp_active = a;
      stim_rows.push_back(row);
   endtask

   always @(posedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 15);
   end

   always @(posedge clock) begin
      beep_out_type exp_out;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual sample %0d active %0b",
                     $time, rsp_sample, rsp_active);
            mismatch_count++;
         end else begin
            exp_out = pending_samples.pop_front();
            if (rsp_sample !== exp_out.sample) begin
               $display("%0t: sample mismatch, expected %0d, actual %0d",
                        $time, $signed(exp_out.sample), rsp_sample);
               mismatch_count++;
            end
            if (rsp_active !== exp_out.active) begin
               $display("%0t: active mismatch, expected %0b, actual %0b",
                        $time, exp_out.active, rsp_active);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      logic prev_csr;
      logic [esb_pkg::CFG_LEN_W-1:0] atk;
      logic [esb_pkg::CFG_LEN_W-1:0] trn;
      logic [esb_pkg::CFG_LEN_W-1:0] rel;
      logic [esb_pkg::LEVEL_W-1:0] pk;
      logic [esb_pkg::LEVEL_W-1:0] sus;
      logic [esb_pkg::PHASE_W-1:0] step;
      logic [esb_pkg::NOTE_W-1:0] len;
      int span;
      int phase_start;
      int n;
      int r;
      logic paused;

      cfg_step = esb_pkg::RESET_TONE_PHASE_STEP;
      cfg_attack = esb_pkg::RESET_ATTACK_LENGTH;
      cfg_trans = esb_pkg::RESET_TRANSITION_LENGTH;
      cfg_release = esb_pkg::RESET_RELEASE_LENGTH;
      cfg_peak = esb_pkg::RESET_PEAK_LEVEL;
      cfg_sustain = esb_pkg::RESET_SUSTAIN_LEVEL;
      note_left = '0;
      note_age = '0;
      tone_phase = '0;

      // reset defaults: phase step zero keeps every sounding sample at zero
      add_row(ROW_TICK, '0, '0, 1'b1, 16'sd0, 1'b0);
      add_row(ROW_LOAD, '0, 32'd0, 1'b0, '0, 1'b0);
      add_row(ROW_TICK, '0, '0, 1'b1, 16'sd0, 1'b0);
      add_row(ROW_LOAD, '0, 32'd2, 1'b0, '0, 1'b0);
      add_row(ROW_TICK, '0, '0, 1'b1, 16'sd0, 1'b1);
      add_row(ROW_TICK, '0, '0, 1'b1, 16'sd0, 1'b1);
      add_row(ROW_TICK, '0, '0, 1'b1, 16'sd0, 1'b0);
      add_row(ROW_LOAD, '0, 32'hFF_FFFF, 1'b0, '0, 1'b0);
      add_row(ROW_TICK, '0, '0, 1'b1, 16'sd0, 1'b1);
      add_row(ROW_LOAD, '0, 32'd0, 1'b0, '0, 1'b0);
      add_row(ROW_TICK, '0, '0, 1'b1, 16'sd0, 1'b0);
      // quarter-turn step, full-scale levels: saturation both ways
      add_row(ROW_CSR, esb_pkg::CSR_TONE_PHASE_STEP, 32'h4000_0000, 1'b0, '0, 1'b0);
      add_row(ROW_CSR, esb_pkg::CSR_ATTACK_LENGTH, 32'hFF00_0001, 1'b0, '0, 1'b0);
      add_row(ROW_CSR, esb_pkg::CSR_TRANSITION_LENGTH, 32'h0000_0001, 1'b0, '0, 1'b0);
      add_row(ROW_CSR, esb_pkg::CSR_RELEASE_LENGTH, 32'h0000_0001, 1'b0, '0, 1'b0);
      add_row(ROW_CSR, esb_pkg::CSR_PEAK_LEVEL, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
      add_row(ROW_CSR, esb_pkg::CSR_SUSTAIN_LEVEL, 32'h0000_FFFF, 1'b0, '0, 1'b0);
      add_row(ROW_CSR, CSR_SPARE_6, 32'h0000_0000, 1'b0, '0, 1'b0);
      add_row(ROW_CSR, CSR_SPARE_7, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
      add_row(ROW_LOAD, '0, 32'd12, 1'b0, '0, 1'b0);
      repeat (5) add_row(ROW_TICK, '0, '0, 1'b0, '0, 1'b0);
      add_row(ROW_LOAD, '0, 32'd1, 1'b0, '0, 1'b0);
      add_row(ROW_TICK, '0, '0, 1'b0, '0, 1'b0);
      add_row(ROW_TICK, '0, '0, 1'b1, 16'sd0, 1'b0);
      // zero lengths: every ramp skipped, sustain only
      add_row(ROW_CSR, esb_pkg::CSR_TONE_PHASE_STEP, 32'h0123_4567, 1'b0, '0, 1'b0);
      add_row(ROW_CSR, esb_pkg::CSR_ATTACK_LENGTH, 32'hA500_0000, 1'b0, '0, 1'b0);
      add_row(ROW_CSR, esb_pkg::CSR_TRANSITION_LENGTH, 32'h5A00_0000, 1'b0, '0, 1'b0);
      add_row(ROW_CSR, esb_pkg::CSR_RELEASE_LENGTH, 32'h0000_0000, 1'b0, '0, 1'b0);
      add_row(ROW_CSR, esb_pkg::CSR_PEAK_LEVEL, 32'h5A5A_0000, 1'b0, '0, 1'b0);
      add_row(ROW_CSR, esb_pkg::CSR_SUSTAIN_LEVEL, 32'd40000, 1'b0, '0, 1'b0);
      add_row(ROW_LOAD, '0, 32'd4, 1'b0, '0, 1'b0);
      repeat (3) add_row(ROW_TICK, '0, '0, 1'b0, '0, 1'b0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      prev_csr = 1'b0;
      for (int i = 0; i < stim_rows.size(); i++) begin
         row = stim_rows[i];
         if (row.kind == ROW_CSR) begin
            if (!prev_csr) begin
               settle_block();
            end
            write_csr(row.index, row.value);
         end else begin
            if (prev_csr) begin
               csr_valid <= 1'b0;
            end
            send_item(row.kind == ROW_LOAD ? esb_pkg::REQ_LOAD : esb_pkg::REQ_TICK,
                      row.value[esb_pkg::NOTE_W-1:0],
                      row.typed, row.exp_sample, row.exp_active);
         end
         prev_csr = (row.kind == ROW_CSR);
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         quiet = 1'b0;
         settle_block();
         case (ph)
            0: begin
               step = $urandom;
               atk = {esb_pkg::CFG_LEN_W{1'b1}};
               trn = {esb_pkg::CFG_LEN_W{1'b1}};
               rel = {esb_pkg::CFG_LEN_W{1'b1}};
               pk = 16'hFFFF;
               sus = 16'h0000;
            end
            1: begin
               step = 32'hFFFF_FFFF;
               atk = 24'd1;
               trn = 24'd1;
               rel = 24'd1;
               pk = 16'h0000;
               sus = 16'hFFFF;
            end
            default: begin
               step = $urandom;
               atk = esb_pkg::CFG_LEN_W'($urandom_range(1, 48));
               trn = esb_pkg::CFG_LEN_W'($urandom_range(1, 48));
               rel = esb_pkg::CFG_LEN_W'($urandom_range(1, 48));
               pk = esb_pkg::LEVEL_W'($urandom);
               sus = esb_pkg::LEVEL_W'($urandom);
            end
         endcase
         write_csr(esb_pkg::CSR_TONE_PHASE_STEP, step);
         write_csr(esb_pkg::CSR_ATTACK_LENGTH, {8'($urandom), atk});
         write_csr(esb_pkg::CSR_TRANSITION_LENGTH, {8'($urandom), trn});
         write_csr(esb_pkg::CSR_RELEASE_LENGTH, {8'($urandom), rel});
         write_csr(esb_pkg::CSR_PEAK_LEVEL, {16'($urandom), pk});
         write_csr(esb_pkg::CSR_SUSTAIN_LEVEL, {16'($urandom), sus});
         write_csr($urandom_range(0, 1) ? CSR_SPARE_6 : CSR_SPARE_7, $urandom);
         csr_valid <= 1'b0;
         quiet = (ph == 2);

         span = int'(atk) + int'(trn) + int'(rel) + 16;
         if (span > 300 || span < 1) begin
            span = 300;
         end
         phase_start = items_sent;
         paused = 1'b0;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            if (ph == 3 && !paused && items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
               drain_results();
               paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
               len = esb_pkg::NOTE_W'($urandom_range(1, span));
               send_load(len);
               if ($urandom_range(0, 3) == 0) begin
                  n = $urandom_range(0, int'(len));
               end else begin
                  n = int'(len) + $urandom_range(0, 2);
               end
               repeat (n) send_tick();
            end else if (r < 90) begin
               send_load(esb_pkg::NOTE_W'($urandom));
               repeat ($urandom_range(1, 4)) send_tick();
            end else begin
               repeat ($urandom_range(1, 3)) send_tick();
            end
         end
      end

      quiet = 1'b0;
      settle_block();
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/esb_pkg.sv
rtl/esb_sine_rom.sv
rtl/esb_mul_div.sv
rtl/enveloped_sine_beeper.sv
sim/enveloped_sine_beeper_tb.sv
